/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define SBQ_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SBQ_ASSERT(lbl, clk, rst_n, prop)
`define SBQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/sbq_pkg.sv */
// ----------------------------------------------------------------------------
// sbq_pkg
// request modes, status codes and field widths of the semaphore queue table
// ----------------------------------------------------------------------------
package sbq_pkg;
	localparam int ModeBits   = 2;
	localparam int SemBits    = 32;
	localparam int PidBits    = 5;
	localparam int StatusBits = 2;

	typedef logic [ModeBits-1:0]   mode_t;
	typedef logic [StatusBits-1:0] status_t;

	localparam mode_t MODE_BLOCK   = 2'd0;
	localparam mode_t MODE_UNBLOCK = 2'd1;
	localparam mode_t MODE_PULL    = 2'd2;
	localparam mode_t MODE_PEEK    = 2'd3;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOFREE   = 2'd1;
	localparam status_t ST_NOTFOUND = 2'd2;
	localparam status_t ST_REPEAT   = 2'd3;
endpackage

/* hw/rtl/sbq_req_if.sv */
// ----------------------------------------------------------------------------
// sbq_req_if
// request channel: mode, semaphore address and process id
// ----------------------------------------------------------------------------
interface sbq_req_if;
	logic                           valid;
	logic                           ready;
	sbq_pkg::mode_t                 mode;
	logic [sbq_pkg::SemBits-1:0]    sem_addr;
	logic [sbq_pkg::PidBits-1:0]    proc_id;

	modport source (output valid, mode, sem_addr, proc_id, input ready);
	modport sink (input valid, mode, sem_addr, proc_id, output ready);
endinterface

/* hw/rtl/sbq_rsp_if.sv */
// ----------------------------------------------------------------------------
// sbq_rsp_if
// response channel: returned process and status
// ----------------------------------------------------------------------------
interface sbq_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           has_proc;
	logic [sbq_pkg::PidBits-1:0]    result_proc;
	sbq_pkg::status_t               status;

	modport source (output valid, has_proc, result_proc, status, input ready);
	modport sink (input valid, has_proc, result_proc, status, output ready);
endinterface

/* hw/rtl/semaphore_blocked_queue_table_unit.sv */
// ----------------------------------------------------------------------------
// semaphore_blocked_queue_table_unit
// active semaphore table with a fifo of blocked processes per descriptor
// ----------------------------------------------------------------------------
// usage: one request on req (valid/ready) gives exactly one response on rsp.
// block (mode 0) queues proc_id on the semaphore at sem_addr, claiming the
// lowest free descriptor for a new semaphore; unblock (1) pops the head,
// pull out (2) removes proc_id from its queue, peek (3) returns the head.
// a descriptor whose queue empties returns to the free pool.
// the descriptor lookup reads one address a cycle from the address memory
// for modes 0, 1 and 3; pull out instead walks the link memory, each hop
// passing through the walk and next-link states.
// req.ready is high only while the sequencer is idle, so one request is in
// work at a time; a new request is taken only after the last one is done.
// the response sits in an output register; a new request may be taken while
// it waits, but its own response is held back until rsp.ready takes the old.
// reset clears the in-use and blocked flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module semaphore_blocked_queue_table_unit #(
	parameter int NUM_PROCS = 32,
	parameter int ADDR_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sbq_req_if.sink      req,
	sbq_rsp_if.source    rsp
);
	localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int CW = $clog2(NUM_PROCS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_FOUND = 4'd3;
	localparam logic [3:0] S_HT    = 4'd4;
	localparam logic [3:0] S_UL    = 4'd5;
	localparam logic [3:0] S_NOTF  = 4'd6;
	localparam logic [3:0] S_B2    = 4'd7;
	localparam logic [3:0] S_PD    = 4'd8;
	localparam logic [3:0] S_PHT   = 4'd9;
	localparam logic [3:0] S_WALK  = 4'd10;
	localparam logic [3:0] S_WNXT  = 4'd11;
	localparam logic [3:0] S_PLINK = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;

	logic [3:0]                   state_q;
	sbq_pkg::mode_t               mode_q;
	logic [ADDR_BITS-1:0]         addr_q;
	logic [sbq_pkg::PidBits-1:0]  pid_raw_q;
	logic [PW-1:0]                pid;
	logic [PW-1:0]                did_q, head_q, tail_q, cur_q, prev_q, free_idx_q;
	logic                         free_ok_q;
	logic [CW-1:0]                cnt_q;
	logic                         sv_s1;
	logic [PW-1:0]                si_s1;
	logic                         res_has_q;
	logic [PW-1:0]                res_proc_q;
	sbq_pkg::status_t             res_st_q;
	logic                         out_valid_q;
	logic                         out_has_q;
	logic [sbq_pkg::PidBits-1:0]  out_proc_q;
	sbq_pkg::status_t             out_st_q;

	logic [NUM_PROCS-1:0]         used_q, blocked_q;

	logic [ADDR_BITS-1:0]         addr_mem [NUM_PROCS];
	logic [PW-1:0]                head_mem [NUM_PROCS];
	logic [PW-1:0]                tail_mem [NUM_PROCS];
	logic [PW-1:0]                link_mem [NUM_PROCS];
	logic [PW-1:0]                pdesc_mem [NUM_PROCS];

	logic [ADDR_BITS-1:0]         addr_rd_q;
	logic [PW-1:0]                head_rd_q, tail_rd_q, link_rd_q, pdesc_rd_q;
	logic [PW-1:0]                link_ra, ht_ra;

	logic                         addr_we, head_we, tail_we, link_we, pdesc_we;
	logic [PW-1:0]                addr_wa, head_wa, tail_wa, link_wa, pdesc_wa;
	logic [PW-1:0]                head_wd, tail_wd, link_wd, pdesc_wd;

	logic                         accept, pbad, issue, match;

	assign pid    = PW'(pid_raw_q);
	assign accept = req.valid && req.ready;
	assign pbad   = 32'(pid_raw_q) >= NUM_PROCS;
	assign issue  = cnt_q < CW'(NUM_PROCS);
	assign match  = sv_s1 && used_q[si_s1] && (addr_rd_q == addr_q);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.has_proc    = out_has_q;
	assign rsp.result_proc = out_proc_q;
	assign rsp.status      = out_st_q;

	assign link_ra = (state_q == S_HT) ? head_rd_q : cur_q;
	assign ht_ra   = (state_q == S_PD) ? pdesc_rd_q : did_q;

	// memory write ports
	always_comb begin
		addr_we  = 1'b0; addr_wa  = free_idx_q;
		head_we  = 1'b0; head_wa  = did_q; head_wd = pid;
		tail_we  = 1'b0; tail_wa  = did_q; tail_wd = pid;
		link_we  = 1'b0; link_wa  = pid;   link_wd = pid;
		pdesc_we = 1'b0; pdesc_wa = pid;   pdesc_wd = did_q;
		case (state_q)
			S_HT: begin
				if (mode_q == sbq_pkg::MODE_BLOCK) begin
					link_we = 1'b1;
					link_wa = tail_rd_q;
					tail_we = 1'b1;
				end
			end
			S_UL: begin
				head_we = 1'b1;
				head_wd = link_rd_q;
			end
			S_NOTF: begin
				if (mode_q == sbq_pkg::MODE_BLOCK && free_ok_q) begin
					addr_we = 1'b1;
					head_we = 1'b1;
					head_wa = free_idx_q;
					tail_we = 1'b1;
					tail_wa = free_idx_q;
				end
			end
			S_B2: begin
				link_we  = 1'b1;
				pdesc_we = 1'b1;
			end
			S_PLINK: begin
				if (pid == head_q && pid != tail_q) begin
					head_we = 1'b1;
					head_wd = link_rd_q;
				end else if (pid != head_q) begin
					link_we = 1'b1;
					link_wa = prev_q;
					link_wd = link_rd_q;
					tail_we = (pid == tail_q);
					tail_wd = prev_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (addr_we) addr_mem[addr_wa] <= addr_q;
		if (head_we) head_mem[head_wa] <= head_wd;
		if (tail_we) tail_mem[tail_wa] <= tail_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (pdesc_we) pdesc_mem[pdesc_wa] <= pdesc_wd;
		addr_rd_q  <= addr_mem[cnt_q[PW-1:0]];
		si_s1      <= cnt_q[PW-1:0];
		head_rd_q  <= head_mem[ht_ra];
		tail_rd_q  <= tail_mem[ht_ra];
		link_rd_q  <= link_mem[link_ra];
		pdesc_rd_q <= pdesc_mem[pid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			blocked_q   <= '0;
			out_valid_q <= 1'b0;
			sv_s1       <= 1'b0;
			free_ok_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			sv_s1 <= (state_q == S_SCAN) && issue;
			if (out_valid_q && rsp.ready && state_q != S_FIN) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= req.mode;
						addr_q    <= ADDR_BITS'(req.sem_addr);
						pid_raw_q <= req.proc_id;
						state_q   <= S_DEC;
					end
				end
				S_DEC: begin
					res_has_q  <= 1'b0;
					res_proc_q <= '0;
					cnt_q      <= '0;
					free_ok_q  <= 1'b0;
					res_st_q   <= sbq_pkg::ST_NOTFOUND;
					if (mode_q == sbq_pkg::MODE_BLOCK) begin
						if (pbad) state_q <= S_FIN;
						else if (blocked_q[pid]) begin
							res_st_q <= sbq_pkg::ST_REPEAT;
							state_q  <= S_FIN;
						end else state_q <= S_SCAN;
					end else if (mode_q == sbq_pkg::MODE_PULL) begin
						if (pbad || !blocked_q[pid]) state_q <= S_FIN;
						else state_q <= S_PD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) cnt_q <= cnt_q + CW'(1);
					if (sv_s1 && !used_q[si_s1] && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= si_s1;
					end
					if (match) begin
						did_q   <= si_s1;
						state_q <= S_FOUND;
					end else if (sv_s1 && si_s1 == PW'(NUM_PROCS - 1)) begin
						state_q <= S_NOTF;
					end
				end
				S_FOUND: state_q <= S_HT;
				S_HT: begin
					head_q <= head_rd_q;
					if (mode_q == sbq_pkg::MODE_BLOCK) begin
						state_q <= S_B2;
					end else begin
						res_has_q  <= 1'b1;
						res_proc_q <= head_rd_q;
						res_st_q   <= sbq_pkg::ST_OK;
						if (mode_q == sbq_pkg::MODE_PEEK) state_q <= S_FIN;
						else begin
							blocked_q[head_rd_q] <= 1'b0;
							if (head_rd_q == tail_rd_q) begin
								used_q[did_q] <= 1'b0;
								state_q       <= S_FIN;
							end else state_q <= S_UL;
						end
					end
				end
				S_UL: state_q <= S_FIN;
				S_NOTF: begin
					if (mode_q == sbq_pkg::MODE_BLOCK) begin
						if (free_ok_q) begin
							used_q[free_idx_q] <= 1'b1;
							did_q              <= free_idx_q;
							state_q            <= S_B2;
						end else begin
							res_st_q <= sbq_pkg::ST_NOFREE;
							state_q  <= S_FIN;
						end
					end else state_q <= S_FIN;
				end
				S_B2: begin
					blocked_q[pid] <= 1'b1;
					res_st_q       <= sbq_pkg::ST_OK;
					state_q        <= S_FIN;
				end
				S_PD: begin
					did_q <= pdesc_rd_q;
					if (!used_q[pdesc_rd_q]) state_q <= S_FIN;
					else state_q <= S_PHT;
				end
				S_PHT: begin
					head_q  <= head_rd_q;
					tail_q  <= tail_rd_q;
					cur_q   <= head_rd_q;
					prev_q  <= head_rd_q;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (cnt_q == CW'(NUM_PROCS)) state_q <= S_FIN;
					else if (cur_q == pid) state_q <= S_PLINK;
					else if (cur_q == tail_q) state_q <= S_FIN;
					else begin
						prev_q  <= cur_q;
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_WNXT;
					end
				end
				S_WNXT: begin
					cur_q   <= link_rd_q;
					state_q <= S_WALK;
				end
				S_PLINK: begin
					blocked_q[pid] <= 1'b0;
					if (pid == head_q && pid == tail_q) used_q[did_q] <= 1'b0;
					res_has_q  <= 1'b1;
					res_proc_q <= pid;
					res_st_q   <= sbq_pkg::ST_OK;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_has_q   <= res_has_q;
						out_proc_q  <= res_has_q ? sbq_pkg::PidBits'(res_proc_q) : '0;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SBQ_ASSERT(a_ok_only_with_proc, clk, arst_n, (out_valid_q && out_has_q) |-> (out_st_q == sbq_pkg::ST_OK))
	`SBQ_ASSERT(a_accept_decodes, clk, arst_n, accept |=> (state_q == S_DEC))
	`SBQ_ASSERT(a_scan_bound, clk, arst_n, (state_q == S_SCAN) |-> (cnt_q <= CW'(NUM_PROCS)))
	`SBQ_ASSERT(a_rsp_from_fin, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_FIN))
endmodule

/* sim/sbq_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_tb_pkg
// semaphore queue table predictor and response scoreboard for the testbench
// ----------------------------------------------------------------------------
package sbq_tb_pkg;
	localparam int NPROC = 32;

	typedef struct packed {
		logic                         has_proc;
		logic [sbq_pkg::PidBits-1:0]  result_proc;
		sbq_pkg::status_t             status;
	} sem_rsp_t;

	class sem_table_sb;
		bit                          used [NPROC];
		logic [sbq_pkg::SemBits-1:0] sem [NPROC];
		logic [sbq_pkg::PidBits-1:0] head [NPROC];
		logic [sbq_pkg::PidBits-1:0] tail [NPROC];
		logic [sbq_pkg::PidBits-1:0] link [NPROC];
		bit                          blocked [NPROC];
		logic [sbq_pkg::PidBits-1:0] owner [NPROC];
		sem_rsp_t                    pending_rsp [$];
		int                          errors;

		function new();
			errors = 0;
			for (int i = 0; i < NPROC; i++) begin
				used[i] = 0;
				blocked[i] = 0;
			end
		endfunction

		function int lookup(logic [sbq_pkg::SemBits-1:0] a);
			for (int d = 0; d < NPROC; d++)
				if (used[d] && sem[d] == a)
					return d;
			return -1;
		endfunction

		function sem_rsp_t apply(sbq_pkg::mode_t m, logic [sbq_pkg::SemBits-1:0] a,
			logic [sbq_pkg::PidBits-1:0] p);
			sem_rsp_t r;
			int d;
			logic [sbq_pkg::PidBits-1:0] h, cur, prev;
			bit found;
			r = '{1'b0, '0, sbq_pkg::ST_OK};
			case (m)
				sbq_pkg::MODE_BLOCK: begin
					if (blocked[p]) begin
						r.status = sbq_pkg::ST_REPEAT;
						return r;
					end
					d = lookup(a);
					if (d >= 0) begin
						link[tail[d]] = p;
						tail[d] = p;
					end else begin
						d = 0;
						while (d < NPROC && used[d])
							d++;
						if (d >= NPROC) begin
							r.status = sbq_pkg::ST_NOFREE;
							return r;
						end
						used[d] = 1;
						sem[d] = a;
						head[d] = p;
						tail[d] = p;
					end
					link[p] = p;
					blocked[p] = 1;
					owner[p] = d[sbq_pkg::PidBits-1:0];
				end
				sbq_pkg::MODE_UNBLOCK, sbq_pkg::MODE_PEEK: begin
					d = lookup(a);
					if (d < 0) begin
						r.status = sbq_pkg::ST_NOTFOUND;
						return r;
					end
					h = head[d];
					if (m == sbq_pkg::MODE_UNBLOCK) begin
						blocked[h] = 0;
						if (h == tail[d])
							used[d] = 0;
						else
							head[d] = link[h];
					end
					r.has_proc = 1;
					r.result_proc = h;
				end
				default: begin
					if (!blocked[p] || !used[owner[p]]) begin
						r.status = sbq_pkg::ST_NOTFOUND;
						return r;
					end
					d = owner[p];
					cur = head[d];
					prev = cur;
					found = 0;
					for (int i = 0; i < NPROC; i++) begin
						if (cur == p) begin
							found = 1;
							break;
						end
						if (cur == tail[d])
							break;
						prev = cur;
						cur = link[cur];
					end
					if (!found) begin
						r.status = sbq_pkg::ST_NOTFOUND;
						return r;
					end
					blocked[p] = 0;
					if (p == head[d] && p == tail[d])
						used[d] = 0;
					else if (p == head[d])
						head[d] = link[p];
					else begin
						link[prev] = link[p];
						if (p == tail[d])
							tail[d] = prev;
					end
					r.has_proc = 1;
					r.result_proc = p;
				end
			endcase
			return r;
		endfunction

		function void note_request(sbq_pkg::mode_t m, logic [sbq_pkg::SemBits-1:0] a,
			logic [sbq_pkg::PidBits-1:0] p);
			pending_rsp.push_back(apply(m, a, p));
		endfunction

		function void check_response(sem_rsp_t got);
			sem_rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response %p", got);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.has_proc !== want.has_proc) begin
				$error("has_proc expected %0d actual %0d", want.has_proc, got.has_proc);
				errors++;
			end
			if (got.result_proc !== want.result_proc) begin
				$error("result_proc expected %0d actual %0d", want.result_proc,
					got.result_proc);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass
endpackage

/* sim/semaphore_blocked_queue_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_blocked_queue_table_unit_tb
// drives block, unblock, pull out and peek requests through the table,
// predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module semaphore_blocked_queue_table_unit_tb;
	localparam int MAX_CYCLES = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic rsp_quiet = 1;
	logic hold_off = 0;
	logic tail_run = 0;
	int   cycles = 0;
	sbq_tb_pkg::sem_table_sb table_sb = new();
	logic [sbq_pkg::SemBits-1:0] sem_pool [8];

	sbq_req_if req ();
	sbq_rsp_if rsp ();

	semaphore_blocked_queue_table_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		req.valid = 0;
		req.mode = sbq_pkg::MODE_BLOCK;
		req.sem_addr = '0;
		req.proc_id = '0;
		rsp.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (req.valid && req.ready)
			table_sb.note_request(req.mode, req.sem_addr, req.proc_id);
		if (rsp.valid && rsp.ready)
			table_sb.check_response('{rsp.has_proc, rsp.result_proc, rsp.status});
	end

	// response side stalls in bursts, plus one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp.ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!tail_run && $urandom_range(0, 3) == 0) begin
				rsp.ready <= 0;
				n = $urandom_range(1, 8);
				repeat (n) @(posedge clk);
			end else begin
				rsp.ready <= 1;
				@(posedge clk);
			end
		end
	end

	task automatic send(sbq_pkg::mode_t m, logic [sbq_pkg::SemBits-1:0] a,
		logic [sbq_pkg::PidBits-1:0] p);
		int n;
		if (!tail_run && $urandom_range(0, 4) == 0) begin
			req.valid <= 0;
			n = $urandom_range(1, 8);
			repeat (n) @(posedge clk);
		end
		req.valid <= 1;
		req.mode <= m;
		req.sem_addr <= a;
		req.proc_id <= p;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic random_request();
		sbq_pkg::mode_t m;
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) m = sbq_pkg::MODE_BLOCK;
		else if (k < 6) m = sbq_pkg::MODE_UNBLOCK;
		else if (k < 8) m = sbq_pkg::MODE_PULL;
		else m = sbq_pkg::MODE_PEEK;
		if ($urandom_range(0, 9) == 0)
			send(m, $urandom, sbq_pkg::PidBits'($urandom));
		else
			send(m, sem_pool[$urandom_range(0, 7)], sbq_pkg::PidBits'($urandom));
	endtask

	initial begin
		sem_pool[0] = '0;
		sem_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			sem_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, extremes, repeat block, pool full
		send(sbq_pkg::MODE_PEEK, '0, '0);
		send(sbq_pkg::MODE_UNBLOCK, '1, '0);
		send(sbq_pkg::MODE_PULL, '0, 5'd31);
		send(sbq_pkg::MODE_BLOCK, '0, 5'd0);
		send(sbq_pkg::MODE_BLOCK, '0, 5'd0);
		send(sbq_pkg::MODE_BLOCK, '0, 5'd31);
		send(sbq_pkg::MODE_BLOCK, '1, 5'd7);
		send(sbq_pkg::MODE_PEEK, '0, '0);
		send(sbq_pkg::MODE_PULL, '0, 5'd31);
		send(sbq_pkg::MODE_UNBLOCK, '0, '1);
		send(sbq_pkg::MODE_UNBLOCK, '0, '0);
		send(sbq_pkg::MODE_PULL, '1, 5'd7);
		for (int i = 0; i < 32; i++)
			send(sbq_pkg::MODE_BLOCK, 32'h8000_0000 + i, i[sbq_pkg::PidBits-1:0]);
		send(sbq_pkg::MODE_BLOCK, '1, 5'd3);
		for (int i = 0; i < 32; i++)
			send(sbq_pkg::MODE_UNBLOCK, 32'h8000_0000 + i, '0);

		// long hold-off on responses while requests keep coming
		hold_off = 1;
		for (int i = 0; i < 20; i++)
			random_request();

		for (int i = 0; i < 700; i++)
			random_request();
		tail_run = 1;
		for (int i = 0; i < 100; i++)
			random_request();
		req.valid <= 0;

		while (table_sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (table_sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
